FILE: hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and phase-stepping functions of the stepper phase
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int unsigned NUM_MOTORS = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_STEP_MODE       = 2'd0;
  localparam logic [1:0] REG_PATTERN_TABLE   = 2'd1;
  localparam logic [1:0] REG_STANDBY_PATTERN = 2'd2;

  // Step modes (code 3 behaves as full step)
  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_QUARTER = 2'd1;
  localparam logic [1:0] MODE_HALF    = 2'd2;

  // Actions
  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_FATAL = 2'd2;

  typedef struct packed {
    logic       action;
    logic [1:0] motor_select;
    logic       direction;
    logic       limit_before;
    logic       limit_after;
    logic       move_last;
  } in_item_t;

  typedef struct packed {
    logic       drive_valid;
    logic [7:0] coil_pattern;
    logic [2:0] phase_index;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Control from the step unit back to the state registers
  typedef struct packed {
    logic       two_res;   // back-off: a second result follows
    logic       state_we;  // update in_move
    logic       in_move;   // new in_move value
    logic       run_we;    // update running phase
    logic       store_we;  // write phase to the motor's store entry
    logic [2:0] phase;     // phase to keep
  } step_ctl_t;

  function automatic logic [2:0] phase_fwd(input logic [2:0] p, input logic [1:0] mode);
    logic [2:0] r;
    case (mode)
      MODE_QUARTER: r = p[0] ? p + 3'd1 : p + 3'd2;
      MODE_HALF:    r = p[0] ? p + 3'd2 : p + 3'd1;
      default:      r = p + 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] phase_rev(input logic [2:0] p, input logic [1:0] mode);
    logic [2:0] r;
    case (mode)
      MODE_QUARTER: begin
        if (p[0]) begin
          r = (p == 3'd1) ? 3'd6 : p - 3'd1;
        end else begin
          r = p - 3'd2;
        end
      end
      MODE_HALF: r = p[0] ? p - 3'd2 : p - 3'd1;
      default:   r = p - 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pattern_of(input logic [63:0] tbl, input logic [2:0] p);
    return tbl[{p, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sps_step_unit.sv
// ----------------------------------------------------------------------------
// sps_step_unit
// Next-phase logic: picks the start phase, steps it under the mode's wrap
// rules and forms the result items and the state update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_step_unit (
  input  wire sps_pkg::in_item_t  item_i,
  input  wire logic [2:0]         store_phase_i,
  input  wire logic [2:0]         running_phase_i,
  input  wire logic               in_move_i,
  input  wire logic [1:0]         step_mode_i,
  input  wire logic [63:0]        pattern_table_i,
  input  wire logic [7:0]         standby_pattern_i,
  output sps_pkg::out_item_t      res0_o,
  output sps_pkg::out_item_t      res1_o,
  output sps_pkg::step_ctl_t      ctl_o
);
  import sps_pkg::*;

  logic [2:0] cur, nxt, back;

  assign cur  = in_move_i ? running_phase_i : store_phase_i;
  assign nxt  = item_i.direction ? phase_fwd(cur, step_mode_i) : phase_rev(cur, step_mode_i);
  assign back = item_i.direction ? phase_rev(nxt, step_mode_i) : phase_fwd(nxt, step_mode_i);

  always_comb begin
    ctl_o  = '0;
    ctl_o.phase = nxt;
    res1_o = '{drive_valid: 1'b1, coil_pattern: pattern_of(pattern_table_i, back),
               phase_index: back, status: ST_LIMIT, last: 1'b1};
    res0_o = '{drive_valid: 1'b1, coil_pattern: pattern_of(pattern_table_i, nxt),
               phase_index: nxt, status: ST_OK, last: 1'b1};
    if (item_i.action == ACT_RELEASE) begin
      res0_o = '{drive_valid: 1'b1, coil_pattern: standby_pattern_i,
                 phase_index: 3'd0, status: ST_OK, last: 1'b1};
    end else if (!in_move_i && item_i.limit_before) begin
      // fatal at move start: no drive, state untouched
      res0_o = '{drive_valid: 1'b0, coil_pattern: 8'd0,
                 phase_index: 3'd0, status: ST_FATAL, last: 1'b1};
    end else if (item_i.limit_after) begin
      // back off and abort the move without saving
      res0_o.last    = 1'b0;
      ctl_o.two_res  = 1'b1;
      ctl_o.state_we = 1'b1;
      ctl_o.in_move  = 1'b0;
    end else if (item_i.move_last) begin
      ctl_o.state_we = 1'b1;
      ctl_o.in_move  = 1'b0;
      ctl_o.store_we = 1'b1;
    end else begin
      ctl_o.state_we = 1'b1;
      ctl_o.in_move  = 1'b1;
      ctl_o.run_we   = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stepper_phase_sequencer_core.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer_core
// Flow: an item's transfer loads the step stage and issues the motor phase
//   store read; its result then enters the output register from that stage.
// Throughput: one item per cycle while the output does not stall; a back-off
//   item holds the step stage, one result at a time in the output register.
// Reset: control and configuration registers clear; store entries never
//   written read as phase zero through per-entry valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer_core #(
  parameter int unsigned NumMotors = sps_pkg::NUM_MOTORS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item input
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sps_pkg::in_item_t  in_item_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sps_pkg::out_item_t      out_item_o,
  // configuration writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_wdata_i
);
  import sps_pkg::*;

  localparam int unsigned AddrW = (NumMotors > 1) ? $clog2(NumMotors) : 1;
  localparam logic [4:0] NumM = 5'(NumMotors);

  // --------------------------------------------------------------------------
  // Configuration registers, always ready; unchecked by the block, the user must make writes land only while idle
  // --------------------------------------------------------------------------
  logic [1:0]  step_mode_q;
  logic [63:0] pattern_table_q;
  logic [7:0]  standby_pattern_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_mode_q       <= MODE_FULL;
      pattern_table_q   <= '0;
      standby_pattern_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_MODE:       step_mode_q       <= cfg_wdata_i[1:0];
        REG_PATTERN_TABLE:   pattern_table_q   <= cfg_wdata_i;
        REG_STANDBY_PATTERN: standby_pattern_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Motor select reduced modulo the motor count (select is only 2 bits wide,
  // so three conditional subtracts cover every count)
  // --------------------------------------------------------------------------
  logic [4:0]       sel_red;
  logic [AddrW-1:0] in_addr;

  always_comb begin
    sel_red = {3'b000, in_item_i.motor_select};
    for (int k = 0; k < 3; k++) begin
      if (sel_red >= NumM) begin
        sel_red = sel_red - NumM;
      end
    end
  end

  assign in_addr = sel_red[AddrW-1:0];

  // --------------------------------------------------------------------------
  // Step stage: one item, its RAM read data and forwarding info
  // --------------------------------------------------------------------------
  logic             s1_vld_q;
  logic             s1_sub_q;     // second result of a back-off is due
  in_item_t         s1_item_q;
  logic [AddrW-1:0] s1_addr_q;
  logic             s1_fwd_q;     // entry written at the edge the read issued
  logic [2:0]       s1_fwd_data_q;

  logic             in_move_q;
  logic [2:0]       running_q;
  logic [NumMotors-1:0] entry_vld_q;

  out_item_t        res0, res1;
  step_ctl_t        ctl;
  logic [2:0]       ram_rdata;
  logic [2:0]       store_phase;

  logic in_xfer, out_free, emit, s1_done, st_we;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign emit       = s1_vld_q && out_free;
  assign s1_done    = emit && (!ctl.two_res || s1_sub_q);
  assign in_stall_o = s1_vld_q && !s1_done;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign st_we      = s1_done && ctl.store_we;

  // Take the forwarded write first, then stored data, else the reset phase.
  always_comb begin
    if (s1_fwd_q) begin
      store_phase = s1_fwd_data_q;
    end else if (entry_vld_q[s1_addr_q]) begin
      store_phase = ram_rdata;
    end else begin
      store_phase = 3'd0;
    end
  end

  sps_ram #(
    .Width (3),
    .Depth (NumMotors)
  ) u_phase_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_addr_q),
    .wdata_i (ctl.phase),
    .re_i    (in_xfer),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  sps_step_unit u_step (
    .item_i            (s1_item_q),
    .store_phase_i     (store_phase),
    .running_phase_i   (running_q),
    .in_move_i         (in_move_q),
    .step_mode_i       (step_mode_q),
    .pattern_table_i   (pattern_table_q),
    .standby_pattern_i (standby_pattern_q),
    .res0_o            (res0),
    .res1_o            (res1),
    .ctl_o             (ctl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_sub_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_vld_q <= 1'b1;
      end else if (s1_done) begin
        s1_vld_q <= 1'b0;
      end
      // advance to the back-off result once the first one is out
      if (s1_done) begin
        s1_sub_q <= 1'b0;
      end else if (emit && ctl.two_res) begin
        s1_sub_q <= 1'b1;
      end
    end
  end

  // Payload of the step stage; catch a same-entry write racing the read.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q     <= in_item_i;
      s1_addr_q     <= in_addr;
      s1_fwd_q      <= st_we && (s1_addr_q == in_addr);
      s1_fwd_data_q <= ctl.phase;
    end
  end

  // --------------------------------------------------------------------------
  // Move state and per-entry valid bits, committed with the item's last result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_move_q   <= 1'b0;
      running_q   <= 3'd0;
      entry_vld_q <= '0;
    end else if (s1_done) begin
      if (ctl.state_we) begin
        in_move_q <= ctl.in_move;
      end
      if (ctl.run_we) begin
        running_q <= ctl.phase;
      end
      if (ctl.store_we) begin
        entry_vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: holds a result until its transfer, frees the step stage
  // --------------------------------------------------------------------------
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= s1_sub_q ? res1 : res0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stepper_phase_sequencer_core. A table of directed
// items and register writes covers the corner cases: fatal start, limit
// fault ignored mid-move, back-off, release inside a move, select change,
// every step mode including the spare code. Random phases follow, made
// mostly of whole moves with random content. Every input transfer runs
// through a local model of the sequencer, and each result transfer is
// checked field by field against the oldest pending drive.
// ----------------------------------------------------------------------------

module testbench;

  import sps_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned PRESSURE_CYCLES = 80;
  localparam int unsigned PRESSURE_AT     = 120;
  localparam int unsigned PHASE_ITEMS     = 100;
  localparam int unsigned MAX_PRINTS      = 40;

  // Spare step-mode code; the block treats it as full step.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] PHASE_MODE [4] = '{MODE_FULL, MODE_QUARTER, MODE_HALF, MODE_SPARE};

  // --------------------------------------------------------------------------
  // Clock, reset and DUT connections
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_q  = 1'b0;
  in_item_t    in_item_q   = '0;
  logic        out_stall_q = 1'b0;
  logic        cfg_valid_q = 1'b0;
  logic [1:0]  cfg_index_q = REG_STEP_MODE;
  logic [63:0] cfg_wdata_q = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_item_o;
  logic        cfg_ready_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stepper_phase_sequencer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_q),
    .cfg_wdata_i (cfg_wdata_q)
  );

  // --------------------------------------------------------------------------
  // Sequencer model: configuration copy, per-motor phase store, move state
  // --------------------------------------------------------------------------
  logic [1:0]  cfg_mode     = MODE_FULL;
  logic [63:0] cfg_patterns = '0;
  logic [7:0]  cfg_standby  = '0;
  logic [2:0]  motor_phase [NUM_MOTORS];
  logic [2:0]  run_phase    = '0;
  logic        moving       = 1'b0;

  out_item_t   pending_drives [$];
  int unsigned err_count  = 0;
  int unsigned items_sent = 0;
  bit          calm       = 1'b0;

  initial begin
    foreach (motor_phase[m]) motor_phase[m] = '0;
  end

  // Next phase in the forward direction under the current wrap rules.
  function automatic logic [2:0] phase_ahead(input logic [2:0] p);
    case (cfg_mode)
      MODE_QUARTER: begin
        if (p[0]) return (p == 3'd7) ? 3'd0 : p + 3'd1;
        return (p >= 3'd6) ? 3'd0 : p + 3'd2;
      end
      MODE_HALF: begin
        if (p[0]) return (p == 3'd7) ? 3'd1 : p + 3'd2;
        return p + 3'd1;
      end
      default: return (p == 3'd7) ? 3'd0 : p + 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] phase_behind(input logic [2:0] p);
    case (cfg_mode)
      MODE_QUARTER: begin
        if (p[0]) return (p == 3'd1) ? 3'd6 : p - 3'd1;
        return (p == 3'd0) ? 3'd6 : p - 3'd2;
      end
      MODE_HALF: begin
        if (p == 3'd0) return 3'd7;
        if (p[0]) return (p == 3'd1) ? 3'd7 : p - 3'd2;
        return p - 3'd1;
      end
      default: return (p == 3'd0) ? 3'd7 : p - 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] coil_for(input logic [2:0] p);
    logic [63:0] shifted;
    shifted = cfg_patterns >> (8 * p);
    return shifted[7:0];
  endfunction

  function automatic out_item_t make_result(input logic dv, input logic [7:0] pat,
                                            input logic [2:0] ph, input logic [1:0] st,
                                            input logic lst);
    out_item_t r;
    r.drive_valid  = dv;
    r.coil_pattern = pat;
    r.phase_index  = ph;
    r.status       = st;
    r.last         = lst;
    return r;
  endfunction

  // Apply one accepted item to the model; return the number of drives it
  // causes and the drives themselves.
  function automatic int advance_sequencer(input in_item_t it, output out_item_t res [2]);
    int unsigned sel;
    logic [2:0]  start_ph;
    logic [2:0]  next_ph;
    logic [2:0]  back_ph;
    sel = it.motor_select % NUM_MOTORS;
    res[0] = '0;
    res[1] = '0;
    if (it.action == ACT_RELEASE) begin
      res[0] = make_result(1'b1, cfg_standby, 3'd0, ST_OK, 1'b1);
      return 1;
    end
    // limit_before only counts on the first step of a move
    if (!moving) begin
      if (it.limit_before) begin
        res[0] = make_result(1'b0, 8'h00, 3'd0, ST_FATAL, 1'b1);
        return 1;
      end
      start_ph = motor_phase[sel];
    end else begin
      start_ph = run_phase;
    end
    next_ph = it.direction ? phase_ahead(start_ph) : phase_behind(start_ph);
    if (it.limit_after) begin
      // back off one step the other way, abort, keep nothing
      back_ph = it.direction ? phase_behind(next_ph) : phase_ahead(next_ph);
      res[0] = make_result(1'b1, coil_for(next_ph), next_ph, ST_OK, 1'b0);
      res[1] = make_result(1'b1, coil_for(back_ph), back_ph, ST_LIMIT, 1'b1);
      moving = 1'b0;
      return 2;
    end
    res[0] = make_result(1'b1, coil_for(next_ph), next_ph, ST_OK, 1'b1);
    if (it.move_last) begin
      motor_phase[sel] = next_ph;
      moving = 1'b0;
    end else begin
      run_phase = next_ph;
      moving = 1'b1;
    end
    return 1;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
  endtask

  // Sample at the edge: both sides see pre-edge values, so a result transfer
  // here never belongs to an item accepted at this same edge.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_q) begin
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("result %h with no drive pending", out_item_o));
      end else begin
        want = pending_drives.pop_front();
        check_field("drive_valid", 8'(out_item_o.drive_valid), 8'(want.drive_valid));
        check_field("coil_pattern", out_item_o.coil_pattern, want.coil_pattern);
        check_field("phase_index", 8'(out_item_o.phase_index), 8'(want.phase_index));
        check_field("status", 8'(out_item_o.status), 8'(want.status));
        check_field("last", 8'(out_item_o.last), 8'(want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off to back up the block
  // --------------------------------------------------------------------------
  initial begin : result_sink
    bit pressed;
    pressed = 1'b0;
    wait (rst_ni);
    forever begin
      if (!pressed && items_sent >= PRESSURE_AT) begin
        // hold off long enough that the sender sees in_stall_o rise
        pressed = 1'b1;
        out_stall_q <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
        out_stall_q <= 1'b0;
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_q <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_q <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_q <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one item, hold it until the transfer, then model it. Leave valid
  // high unless a gap is drawn, so back-to-back items never drop valid.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res [2];
    int        n;
    in_valid_q <= 1'b1;
    in_item_q  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n = advance_sequencer(it, res);
    if (typed) begin
      pending_drives.push_back(typed_res);
    end else begin
      for (int k = 0; k < n; k++) pending_drives.push_back(res[k]);
    end
    items_sent++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_q <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every pending drive has come back.
  task automatic wait_idle();
    in_valid_q <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_wdata_q <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_STEP_MODE:       cfg_mode = data[1:0];
      REG_PATTERN_TABLE:   cfg_patterns = data;
      REG_STANDBY_PATTERN: cfg_standby = data[7:0];
      default: ;
    endcase
    cfg_valid_q <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random moves: mostly well-formed, with stray releases, direction flips,
  // select changes, limit faults and some fully random noise items.
  task automatic random_moves(input int unsigned count);
    in_item_t    it;
    in_item_t    rel;
    logic [1:0]  sel;
    logic        dir;
    int unsigned len;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 6) == 0) begin
        it = in_item_t'($urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        sel = 2'($urandom_range(0, NUM_MOTORS - 1));
        dir = 1'($urandom);
        len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0) sel = 2'($urandom);
          it = '0;
          it.action       = ACT_STEP;
          it.motor_select = sel;
          it.direction    = ($urandom_range(0, 7) == 0) ? ~dir : dir;
          it.limit_before = (k == 0) ? ($urandom_range(0, 7) == 0) : 1'($urandom);
          it.limit_after  = ($urandom_range(0, 11) == 0);
          it.move_last    = (k == len - 1);
          send_item(it, 1'b0, '0);
          sent++;
          if ($urandom_range(0, 9) == 0) begin
            rel = in_item_t'($urandom);
            rel.action = ACT_RELEASE;
            send_item(rel, 1'b0, '0);
            sent++;
          end
          // fatal start or back-off ends the move early
          if ((k == 0 && it.limit_before) || it.limit_after) break;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [63:0] data;
    in_item_t    item;
    bit          typed;
    out_item_t   res;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic plan_row_t step_row(input logic act, input logic [1:0] sel,
                                         input logic dir, input logic lb,
                                         input logic la, input logic lst);
    plan_row_t r;
    r = '{default: '0};
    r.item.action       = act;
    r.item.motor_select = sel;
    r.item.direction    = dir;
    r.item.limit_before = lb;
    r.item.limit_after  = la;
    r.item.move_last    = lst;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [63:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic plan_row_t with_result(input plan_row_t r, input out_item_t res);
    plan_row_t t;
    t       = r;
    t.typed = 1'b1;
    t.res   = res;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** stepper_phase_sequencer_core: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_flow
    // reset configuration: full step, all patterns zero, standby zero
    plan.push_back(with_result(step_row(ACT_STEP, 2'd0, 1'b1, 1'b0, 1'b0, 1'b1),
                               make_result(1'b1, 8'h00, 3'd1, ST_OK, 1'b1)));
    plan.push_back(with_result(step_row(ACT_STEP, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1),
                               make_result(1'b1, 8'h00, 3'd7, ST_OK, 1'b1)));
    // fatal start: limit fault with no move running
    plan.push_back(with_result(step_row(ACT_STEP, 2'd2, 1'b1, 1'b1, 1'b0, 1'b0),
                               make_result(1'b0, 8'h00, 3'd0, ST_FATAL, 1'b1)));
    plan.push_back(with_result(step_row(ACT_RELEASE, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1),
                               make_result(1'b1, 8'h00, 3'd0, ST_OK, 1'b1)));
    plan.push_back(cfg_row(REG_PATTERN_TABLE, 64'h8040_2010_0804_0201));
    plan.push_back(cfg_row(REG_STANDBY_PATTERN, 64'h0000_0000_0000_00FF));
    plan.push_back(with_result(step_row(ACT_RELEASE, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0),
                               make_result(1'b1, 8'hFF, 3'd0, ST_OK, 1'b1)));
    // quarter step: move with an ignored limit fault, release mid-move,
    // and a select change on the final step
    plan.push_back(cfg_row(REG_STEP_MODE, 64'(MODE_QUARTER)));
    plan.push_back(step_row(ACT_STEP, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0));
    plan.push_back(step_row(ACT_STEP, 2'd2, 1'b1, 1'b1, 1'b0, 1'b0));
    plan.push_back(step_row(ACT_RELEASE, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(step_row(ACT_STEP, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1));
    plan.push_back(step_row(ACT_STEP, 2'd3, 1'b1, 1'b0, 1'b1, 1'b0));
    // half step: back-off on a step that is also marked final
    plan.push_back(cfg_row(REG_STEP_MODE, 64'(MODE_HALF)));
    plan.push_back(step_row(ACT_STEP, 2'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    plan.push_back(step_row(ACT_STEP, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1));
    plan.push_back(step_row(ACT_STEP, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1));
    // spare mode code behaves as full step
    plan.push_back(cfg_row(REG_STEP_MODE, 64'(MODE_SPARE)));
    plan.push_back(step_row(ACT_STEP, 2'd3, 1'b0, 1'b0, 1'b0, 1'b1));
    plan.push_back(cfg_row(REG_PATTERN_TABLE, '1));
    plan.push_back(step_row(ACT_STEP, 2'd1, 1'b1, 1'b0, 1'b1, 1'b1));
    plan.push_back(cfg_row(REG_STEP_MODE, 64'(MODE_FULL)));
    plan.push_back(step_row(ACT_STEP, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1));

    // hold reset at the start, then release it for good
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].res);
      end
    end

    // random phases, each under its own register setting; the last one runs
    // with no idling on either side
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_reg(REG_STEP_MODE, 64'(PHASE_MODE[ph]));
      write_reg(REG_PATTERN_TABLE, (ph == 1) ? '1 : {$urandom, $urandom});
      write_reg(REG_STANDBY_PATTERN,
                (ph == 2) ? 64'h0000_0000_0000_00FF : 64'($urandom_range(0, 255)));
      if (ph == 3) calm = 1'b1;
      random_moves(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("** stepper_phase_sequencer_core: PASSED **");
    end else begin
      $display("** stepper_phase_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule
